// ----- rtl/lprr_pkg.sv -----
// ----------------------------------------------------------------------------
// lprr_pkg
// Shared codes and controller/datapath interface types for the record ring.
// ----------------------------------------------------------------------------
package lprr_pkg;

  // Command codes carried by the cmd field
  localparam logic [2:0] CMD_RESERVE = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_COMMIT  = 3'd2;
  localparam logic [2:0] CMD_PEEK    = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_RELEASE = 3'd5;

  // Status codes returned with every result
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_CORRUPT   = 3'd4;
  localparam logic [2:0] ST_BAD       = 3'd5;

  // Prefix byte counter width: covers prefixes of up to eight bytes
  localparam int PFX_CNT_W = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                 load_item;
    logic                 pfx_wr;
    logic                 pfx_rd;
    logic                 acc_shift;
    logic                 pay_rd;
    logic                 finish;
    logic [PFX_CNT_W-1:0] cnt;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic go_pfx_wr;
    logic go_pfx_rd;
    logic go_pay_rd;
    logic out_free;
  } ctl_sts_t;

endpackage

// ----- rtl/length_prefixed_record_ring.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_record_ring
// Byte ring of variable-length records with a little-endian length prefix;
// reserve/write/commit on the write side, peek/read/release on the read side.
//
//   channel  direction  handshake             fields
//   in       input      in_valid / in_ready   cmd, record_length, byte_index,
//                                             data_in
//   out      output     out_valid / out_ready status, payload_length,
//                                             payload_offset, data_out,
//                                             used_bytes
//
// One transaction is processed at a time. Each command passes an execute step
// and a finish step that loads its result into the output register. A
// successful reserve first writes the PREFIX_BYTES prefix bytes one by one,
// and a peek that fetches a new prefix reads them one by one and then
// assembles the length, since the ring memory ports are one byte wide.
// The next transaction is accepted while a result still waits in the output
// register; a stalled output holds the following result at its last step.
// Synchronous reset clears the counters and flags; ring contents are not
// cleared and no startup pass is needed.
// ----------------------------------------------------------------------------
module length_prefixed_record_ring import lprr_pkg::*; #(
  parameter int RING_BYTES   = 4096,
  parameter int PREFIX_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] record_length,
  input  logic [11:0] byte_index,
  input  logic [7:0]  data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [11:0] payload_length,
  output logic [11:0] payload_offset,
  output logic [7:0]  data_out,
  output logic [12:0] used_bytes
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  lprr_ctrl #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lprr_datapath #(
    .RING_BYTES   (RING_BYTES),
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .record_length  (record_length),
    .byte_index     (byte_index),
    .data_in        (data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .payload_length (payload_length),
    .payload_offset (payload_offset),
    .data_out       (data_out),
    .used_bytes     (used_bytes),
    .ctl            (ctl),
    .sts            (sts)
  );

endmodule

// ----- rtl/lprr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lprr_ctrl
// Sequencer for the record ring: takes one transaction at a time, steps the
// length prefix through the byte memory and hands the result to the output.
// ----------------------------------------------------------------------------
module lprr_ctrl import lprr_pkg::*; #(
  parameter int PREFIX_BYTES = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_PFXW = 3'd2;
  localparam logic [2:0] S_PFXR = 3'd3;
  localparam logic [2:0] S_PFXL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [PFX_CNT_W-1:0] CNT_LAST = PFX_CNT_W'(PREFIX_BYTES - 1);

  logic [2:0]           state, state_next;
  logic [PFX_CNT_W-1:0] cnt, cnt_next;

  // Decode commands from the current state
  always_comb begin
    in_ready      = (state == S_IDLE);
    ctl.load_item = (state == S_IDLE) && in_valid;
    ctl.pfx_wr    = (state == S_PFXW);
    ctl.pfx_rd    = (state == S_PFXR);
    ctl.acc_shift = ((state == S_PFXR) && (cnt != '0)) || (state == S_PFXL);
    ctl.pay_rd    = (state == S_EXEC) && sts.go_pay_rd;
    ctl.finish    = (state == S_FIN) && sts.out_free;
    ctl.cnt       = cnt;
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cnt_next = '0;
        priority if (sts.go_pfx_wr) state_next = S_PFXW;
        else if (sts.go_pfx_rd)     state_next = S_PFXR;
        else                        state_next = S_FIN;
      end
      S_PFXW: begin
        if (cnt == CNT_LAST) state_next = S_FIN;
        else cnt_next = cnt + 1'b1;
      end
      S_PFXR: begin
        if (cnt == CNT_LAST) state_next = S_PFXL;
        else cnt_next = cnt + 1'b1;
      end
      S_PFXL: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ----- rtl/lprr_datapath.sv -----
// ----------------------------------------------------------------------------
// lprr_datapath
// Ring byte memory, head/tail counters, reservation and peek bookkeeping,
// prefix assembly and the registered result slot.
// ----------------------------------------------------------------------------
module lprr_datapath import lprr_pkg::*; #(
  parameter int RING_BYTES   = 4096,
  parameter int PREFIX_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  cmd,
  input  logic [15:0] record_length,
  input  logic [11:0] byte_index,
  input  logic [7:0]  data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [11:0] payload_length,
  output logic [11:0] payload_offset,
  output logic [7:0]  data_out,
  output logic [12:0] used_bytes,
  input  ctl_cmd_t    ctl,
  output ctl_sts_t    sts
);

  localparam int AW = $clog2(RING_BYTES);
  localparam int CW = AW + 1;
  localparam int LW = 8 * PREFIX_BYTES;
  localparam logic [CW-1:0] RING_C  = CW'(RING_BYTES);
  localparam logic [CW-1:0] PFX_C   = CW'(PREFIX_BYTES);
  localparam logic [31:0]   MAX_LEN = 32'(RING_BYTES - PREFIX_BYTES);

  // Ring memory
  logic [7:0]    ring_store [RING_BYTES];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, rd_data;

  // Held transaction
  logic [2:0]  item_cmd;
  logic [15:0] item_rlen;
  logic [11:0] item_idx;
  logic [7:0]  item_din;

  // Bookkeeping
  logic [CW-1:0] write_count, read_count, reserved_size, peeked_size;
  logic          corrupt;
  logic [CW-1:0] write_count_next, read_count_next;
  logic [CW-1:0] reserved_size_next, peeked_size_next;
  logic          corrupt_next;
  logic [LW-1:0] len_acc;

  // Derived values
  logic [CW-1:0] used, free, needed, resv_len, peek_len, used_next;
  logic [AW-1:0] wofs, rofs;
  logic [31:0]   wofs32, rofs32, resv_len32, peek_len32;
  logic [31:0]   pay_wr_sum, pay_rd_sum;
  logic [63:0]   len64;
  logic          too_large, no_space, wr_ok, rd_ok, peek_corrupt;
  logic [7:0]    pfx_byte;

  // Result before registering
  logic [2:0]  res_status;
  logic [11:0] res_len, res_ofs;
  logic [7:0]  res_data;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_cmd  <= cmd;
      item_rlen <= record_length;
      item_idx  <= byte_index;
      item_din  <= data_in;
    end
  end

  // Checks on the held transaction against the current ring state
  always_comb begin
    used         = write_count - read_count;
    free         = RING_C - used;
    needed       = PFX_C + CW'(item_rlen);
    resv_len     = reserved_size - PFX_C;
    peek_len     = peeked_size - PFX_C;
    wofs         = write_count[AW-1:0] + AW'(PREFIX_BYTES);
    rofs         = read_count[AW-1:0] + AW'(PREFIX_BYTES);
    wofs32       = 32'(wofs);
    rofs32       = 32'(rofs);
    resv_len32   = 32'(resv_len);
    peek_len32   = 32'(peek_len);
    pay_wr_sum   = wofs32 + 32'(item_idx);
    pay_rd_sum   = rofs32 + 32'(item_idx);
    len64        = 64'(len_acc);
    too_large    = 32'(item_rlen) > MAX_LEN;
    no_space     = free < needed;
    wr_ok        = (reserved_size != '0) && (32'(item_idx) < resv_len32);
    rd_ok        = (peeked_size != '0) && (32'(item_idx) < peek_len32);
    peek_corrupt = (used < PFX_C) || (len64 > 64'(used - PFX_C));
  end

  // Status to the controller
  always_comb begin
    sts.go_pfx_wr = (item_cmd == CMD_RESERVE) && !too_large && !no_space;
    sts.go_pfx_rd = (item_cmd == CMD_PEEK) && !corrupt && (peeked_size == '0)
                    && (used != '0);
    sts.go_pay_rd = (item_cmd == CMD_READ) && rd_ok;
    sts.out_free  = !out_valid || out_ready;
  end

  // Little-endian prefix byte; only the low two bytes can be nonzero
  always_comb begin
    if (ctl.cnt == PFX_CNT_W'(0))      pfx_byte = item_rlen[7:0];
    else if (ctl.cnt == PFX_CNT_W'(1)) pfx_byte = item_rlen[15:8];
    else                               pfx_byte = 8'd0;
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = write_count[AW-1:0] + AW'(ctl.cnt);
    mem_wdata = pfx_byte;
    if (ctl.pfx_wr) begin
      mem_we = 1'b1;
    end else if (ctl.finish && (item_cmd == CMD_WRITE) && wr_ok) begin
      mem_we    = 1'b1;
      mem_waddr = pay_wr_sum[AW-1:0];
      mem_wdata = item_din;
    end
    mem_re = ctl.pfx_rd || ctl.pay_rd;
    if (ctl.pfx_rd) mem_raddr = read_count[AW-1:0] + AW'(ctl.cnt);
    else            mem_raddr = pay_rd_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring_store[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= ring_store[mem_raddr];
  end

  // Assemble the prefix, lowest byte read first
  generate
    if (PREFIX_BYTES == 1) begin : g_acc_one
      always_ff @(posedge clk) begin
        if (ctl.acc_shift) len_acc <= rd_data;
      end
    end else begin : g_acc_many
      always_ff @(posedge clk) begin
        if (ctl.acc_shift) len_acc <= {rd_data, len_acc[LW-1:8]};
      end
    end
  endgenerate

  // Resolve the transaction and its state update
  always_comb begin
    res_status         = ST_BAD;
    res_len            = 12'd0;
    res_ofs            = 12'd0;
    res_data           = 8'd0;
    write_count_next   = write_count;
    read_count_next    = read_count;
    reserved_size_next = reserved_size;
    peeked_size_next   = peeked_size;
    corrupt_next       = corrupt;
    unique case (item_cmd)
      CMD_RESERVE: begin
        if (too_large) begin
          res_status = ST_TOO_LARGE;
        end else if (no_space) begin
          res_status = ST_NO_SPACE;
        end else begin
          res_status         = ST_OK;
          reserved_size_next = needed;
          res_len            = item_rlen[11:0];
          res_ofs            = wofs32[11:0];
        end
      end
      CMD_WRITE: begin
        if (wr_ok) begin
          res_status = ST_OK;
          res_len    = resv_len32[11:0];
          res_ofs    = wofs32[11:0];
        end
      end
      CMD_COMMIT: begin
        if (reserved_size != '0) begin
          res_status         = ST_OK;
          write_count_next   = write_count + reserved_size;
          reserved_size_next = '0;
        end
      end
      CMD_PEEK: begin
        if (corrupt) begin
          res_status = ST_CORRUPT;
        end else if (peeked_size != '0) begin
          res_status = ST_OK;
          res_len    = peek_len32[11:0];
          res_ofs    = rofs32[11:0];
        end else if (used == '0) begin
          res_status = ST_EMPTY;
        end else if (peek_corrupt) begin
          res_status   = ST_CORRUPT;
          corrupt_next = 1'b1;
        end else begin
          res_status       = ST_OK;
          peeked_size_next = PFX_C + CW'(len_acc);
          res_len          = len64[11:0];
          res_ofs          = rofs32[11:0];
        end
      end
      CMD_READ: begin
        if (rd_ok) begin
          res_status = ST_OK;
          res_len    = peek_len32[11:0];
          res_ofs    = rofs32[11:0];
          res_data   = rd_data;
        end
      end
      CMD_RELEASE: begin
        if (peeked_size != '0) begin
          res_status       = ST_OK;
          read_count_next  = read_count + peeked_size;
          peeked_size_next = '0;
        end
      end
      default: begin
        res_status = ST_BAD;
      end
    endcase
    used_next = write_count_next - read_count_next;
  end

  // Commit state on finish
  always_ff @(posedge clk) begin
    if (rst) begin
      write_count   <= '0;
      read_count    <= '0;
      reserved_size <= '0;
      peeked_size   <= '0;
      corrupt       <= 1'b0;
    end else if (ctl.finish) begin
      write_count   <= write_count_next;
      read_count    <= read_count_next;
      reserved_size <= reserved_size_next;
      peeked_size   <= peeked_size_next;
      corrupt       <= corrupt_next;
    end
  end

  // Result slot: load on finish, drop on output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      status         <= res_status;
      payload_length <= res_len;
      payload_offset <= res_ofs;
      data_out       <= res_data;
      used_bytes     <= 13'(used_next);
    end
  end

  // Corruption stays until reset
  a_corrupt_sticky: assert property (@(posedge clk) disable iff (rst)
    corrupt |=> corrupt)
    else $error("corrupt flag cleared without reset");

  // Filled span never exceeds the ring
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= RING_C)
    else $error("used span exceeds ring size");

  // Open reservation always fits in the free space
  a_resv_fits: assert property (@(posedge clk) disable iff (rst)
    (32'(used) + 32'(reserved_size)) <= 32'(RING_BYTES))
    else $error("reservation overlaps committed data");

  // Peeked record lies inside the filled span
  a_peek_inside: assert property (@(posedge clk) disable iff (rst)
    peeked_size <= used)
    else $error("peeked record beyond filled span");

endmodule
